/* sv/co2fc_pkg.sv */
// Shared types and constants for the CO2 sensor frame checker.
package co2fc_pkg;

  localparam int unsigned PpmW   = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IndexW = 4;

  localparam logic [IndexW-1:0] FRAME_LEN  = 4'd9;
  localparam logic [IndexW-1:0] POS_START  = 4'd0;
  localparam logic [IndexW-1:0] POS_CMD    = 4'd1;
  localparam logic [IndexW-1:0] POS_PPM_HI = 4'd2;
  localparam logic [IndexW-1:0] POS_PPM_LO = 4'd3;
  localparam logic [IndexW-1:0] POS_STATUS = 4'd5;
  localparam logic [IndexW-1:0] POS_LAST_SUMMED = 4'd7;

  localparam logic [ByteW-1:0] START_BYTE = 8'hFF;
  localparam logic [ByteW-1:0] CMD_BYTE   = 8'h86;

  localparam logic [PpmW-1:0] WARN_RESET  = 16'd1000;
  localparam logic [PpmW-1:0] ALERT_RESET = 16'd2000;
  localparam logic [PpmW-1:0] MAX_RESET   = 16'd10000;

  typedef enum logic [1:0] {
    CMD_RX_BYTE = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    V_OK        = 3'd0,
    V_SHORT     = 3'd1,
    V_BAD_START = 3'd2,
    V_BAD_CMD   = 3'd3,
    V_BAD_SUM   = 3'd4,
    V_RANGE     = 3'd5
  } verdict_e;

  typedef enum logic [1:0] {
    LVL_NORMAL  = 2'd0,
    LVL_WARNING = 2'd1,
    LVL_ALERT   = 2'd2
  } level_e;

  typedef enum logic [1:0] {
    REG_WARN  = 2'd0,
    REG_ALERT = 2'd1,
    REG_MAX   = 2'd2
  } reg_e;

  typedef struct packed {
    logic [PpmW-1:0] warn_level;
    logic [PpmW-1:0] alert_level;
    logic [PpmW-1:0] max_valid;
  } cfg_t;

  typedef struct packed {
    verdict_e         verdict;
    logic [PpmW-1:0]  co2_ppm;
    logic [ByteW-1:0] sensor_status;
    level_e           air_level;
  } result_t;

endpackage

/* sv/co2fc_frame.sv */
// Frame state tracking and verdict logic, one beat per cycle.
module co2fc_frame (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        beat_i,
  input  logic [1:0]                  command_i,
  input  logic [co2fc_pkg::ByteW-1:0] rx_byte_i,
  input  co2fc_pkg::cfg_t             cfg_i,
  output logic                        res_valid_o,
  output co2fc_pkg::result_t          res_o
);

  logic [co2fc_pkg::IndexW-1:0] idx_q, idx_d;
  logic [co2fc_pkg::ByteW-1:0]  sum_q, sum_d;
  co2fc_pkg::verdict_e          err_q, err_d;
  logic [co2fc_pkg::ByteW-1:0]  ppm_hi_q, ppm_hi_d;
  logic [co2fc_pkg::ByteW-1:0]  ppm_lo_q, ppm_lo_d;
  logic [co2fc_pkg::ByteW-1:0]  status_q, status_d;

  logic                         open_frame;
  logic [co2fc_pkg::ByteW-1:0]  expect_sum;
  logic [co2fc_pkg::PpmW-1:0]   ppm;
  co2fc_pkg::verdict_e          err_fin;
  co2fc_pkg::level_e            level;

  assign open_frame = (idx_q < co2fc_pkg::FRAME_LEN);
  assign expect_sum = co2fc_pkg::ByteW'(8'd0 - sum_q);
  assign ppm        = {ppm_hi_q, ppm_lo_q};

  always_comb begin
    err_fin = err_q;
    if (err_q == co2fc_pkg::V_OK && rx_byte_i != expect_sum) begin
      err_fin = co2fc_pkg::V_BAD_SUM;
    end
    if (ppm >= cfg_i.alert_level) begin
      level = co2fc_pkg::LVL_ALERT;
    end else if (ppm >= cfg_i.warn_level) begin
      level = co2fc_pkg::LVL_WARNING;
    end else begin
      level = co2fc_pkg::LVL_NORMAL;
    end
  end

  always_comb begin
    idx_d       = idx_q;
    sum_d       = sum_q;
    err_d       = err_q;
    ppm_hi_d    = ppm_hi_q;
    ppm_lo_d    = ppm_lo_q;
    status_d    = status_q;
    res_valid_o = 1'b0;
    res_o       = '{verdict: co2fc_pkg::V_OK, co2_ppm: '0, sensor_status: '0,
                    air_level: co2fc_pkg::LVL_NORMAL};
    if (beat_i) begin
      case (co2fc_pkg::cmd_e'(command_i))
        co2fc_pkg::CMD_RESTART: begin
          idx_d    = co2fc_pkg::POS_START;
          sum_d    = '0;
          err_d    = co2fc_pkg::V_OK;
          ppm_hi_d = '0;
          ppm_lo_d = '0;
          status_d = '0;
        end
        co2fc_pkg::CMD_TIMEOUT: begin
          if (open_frame) begin
            idx_d         = co2fc_pkg::FRAME_LEN;
            res_valid_o   = 1'b1;
            res_o.verdict = co2fc_pkg::V_SHORT;
          end
        end
        co2fc_pkg::CMD_RX_BYTE: begin
          if (open_frame) begin
            if (idx_q == co2fc_pkg::POS_START) begin
              if (rx_byte_i != co2fc_pkg::START_BYTE && err_q == co2fc_pkg::V_OK) begin
                err_d = co2fc_pkg::V_BAD_START;
              end
              idx_d = idx_q + 4'd1;
            end else if (idx_q <= co2fc_pkg::POS_LAST_SUMMED) begin
              if (idx_q == co2fc_pkg::POS_CMD && rx_byte_i != co2fc_pkg::CMD_BYTE &&
                  err_q == co2fc_pkg::V_OK) begin
                err_d = co2fc_pkg::V_BAD_CMD;
              end
              if (idx_q == co2fc_pkg::POS_PPM_HI) ppm_hi_d = rx_byte_i;
              if (idx_q == co2fc_pkg::POS_PPM_LO) ppm_lo_d = rx_byte_i;
              if (idx_q == co2fc_pkg::POS_STATUS) status_d = rx_byte_i;
              sum_d = sum_q + rx_byte_i;
              idx_d = idx_q + 4'd1;
            end else begin
              // checksum byte: close frame and report
              idx_d       = co2fc_pkg::FRAME_LEN;
              err_d       = err_fin;
              res_valid_o = 1'b1;
              if (err_fin != co2fc_pkg::V_OK) begin
                res_o.verdict = err_fin;
              end else if (ppm == '0 || ppm > cfg_i.max_valid) begin
                res_o.verdict       = co2fc_pkg::V_RANGE;
                res_o.co2_ppm       = ppm;
                res_o.sensor_status = status_q;
              end else begin
                res_o.verdict       = co2fc_pkg::V_OK;
                res_o.co2_ppm       = ppm;
                res_o.sensor_status = status_q;
                res_o.air_level     = level;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= co2fc_pkg::FRAME_LEN;
      sum_q    <= '0;
      err_q    <= co2fc_pkg::V_OK;
      ppm_hi_q <= '0;
      ppm_lo_q <= '0;
      status_q <= '0;
    end else begin
      idx_q    <= idx_d;
      sum_q    <= sum_d;
      err_q    <= err_d;
      ppm_hi_q <= ppm_hi_d;
      ppm_lo_q <= ppm_lo_d;
      status_q <= status_d;
    end
  end

endmodule

/* sv/co2_sensor_frame_checker.sv */
// CO2 sensor frame checker top level: config registers and result register.
// Output: a verdict appears on the master side in the cycle after the beat that causes it.
// Throughput: one beat per cycle; the slave side stalls only while a verdict is held
// in the result register and the master side does not take it.
// Reset: thresholds return to 1000/2000/10000 ppm, no frame is open, output is empty.
module co2_sensor_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] co2_ppm, [23:16] sensor_status, [25:24] air_level
  output logic [2:0]  m_axis_tuser,   // [2:0] verdict
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  co2fc_pkg::cfg_t    cfg_q, cfg_d;
  co2fc_pkg::result_t out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic               beat;
  logic               res_valid;
  co2fc_pkg::result_t res;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign beat          = s_axis_tvalid && s_axis_tready;

  co2fc_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .command_i   (s_axis_tuser),
    .rx_byte_i   (s_axis_tdata),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (co2fc_pkg::reg_e'(cfg_index_i))
        co2fc_pkg::REG_WARN:  cfg_d.warn_level  = cfg_data_i;
        co2fc_pkg::REG_ALERT: cfg_d.alert_level = cfg_data_i;
        co2fc_pkg::REG_MAX:   cfg_d.max_valid   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warn_level  <= co2fc_pkg::WARN_RESET;
      cfg_q.alert_level <= co2fc_pkg::ALERT_RESET;
      cfg_q.max_valid   <= co2fc_pkg::MAX_RESET;
      out_valid_q       <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.verdict;
  assign m_axis_tdata  = {6'd0, out_q.air_level, out_q.sensor_status, out_q.co2_ppm};

endmodule
